// ----- hw/rtl/mcst_pkg.sv -----
// Shared types and constants for the multichannel square tone shifter.
package mcst_pkg;

   localparam int OP_W     = 3;
   localparam int CHAN_W   = 3;
   localparam int PERIOD_W = 16;
   localparam int FRAME_W  = 24;
   localparam int LED_SHIFT = 12;

   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_NOTE_ON   = 3'd1;
   localparam logic [OP_W-1:0] OP_NOTE_OFF  = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET_CH  = 3'd3;
   localparam logic [OP_W-1:0] OP_RESET_ALL = 3'd4;
   localparam logic [OP_W-1:0] OP_HALT_ALL  = 3'd5;

   // Per-channel command, decoded once in the top level.
   typedef struct packed {
      logic                tick;
      logic                load;
      logic                clear_period;
      logic                clear_count;
      logic [PERIOD_W-1:0] period;
   } chan_cmd_type;

endpackage

// ----- hw/rtl/mcst_if.sv -----
// Valid/ready channel interfaces for command beats and frame beats.
interface mcst_req_if import mcst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [CHAN_W-1:0]   channel;
   logic [PERIOD_W-1:0] period;

   modport source (output valid, op, channel, period, input ready);
   modport sink   (input valid, op, channel, period, output ready);
endinterface

interface mcst_rsp_if import mcst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame;

   modport source (output valid, frame, input ready);
   modport sink   (input valid, frame, output ready);
endinterface

// ----- hw/rtl/mcst_chan.sv -----
// One tone channel: half-period register, tick counter and toggle detection.
module mcst_chan
   import mcst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  chan_cmd_type cmd,
   output logic         toggle
);

   logic [PERIOD_W-1:0] half_period_ff, half_period_in;
   logic [PERIOD_W-1:0] tick_count_ff, tick_count_in;
   logic [PERIOD_W-1:0] count_inc;
   logic                running;

   assign running   = (half_period_ff != '0);
   assign count_inc = tick_count_ff + PERIOD_W'(1);
   // A counter left above a lowered half-period toggles on the next tick.
   assign toggle    = cmd.tick && running && (count_inc >= half_period_ff);

   always_comb begin
      half_period_in = half_period_ff;
      tick_count_in  = tick_count_ff;
      if (cmd.tick && running) begin
         tick_count_in = toggle ? '0 : count_inc;
      end
      if (cmd.load) begin
         half_period_in = cmd.period;
      end
      if (cmd.clear_period) begin
         half_period_in = '0;
      end
      if (cmd.clear_count) begin
         tick_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= '0;
         tick_count_ff  <= '0;
      end else if (advance) begin
         half_period_ff <= half_period_in;
         tick_count_ff  <= tick_count_in;
      end
   end

endmodule

// ----- hw/rtl/multichannel_square_tone_shifter.sv -----
// Top level of the multichannel square tone shifter.
//
//  Channel  Role    Beat contents
//  req_bus  sink    op, channel, period
//  rsp_bus  source  frame (LED bits from bit 12, output bits from bit 0)
//
// A command beat is registered in the command stage, then decoded and applied to all
// channels when that stage advances, and its frame is loaded into the output register.
// One beat per cycle is sustained while frames flow; a frame leaves the output register.
// Reset clears every channel, the output and LED bits and both stages.
// A stalled frame holds the command stage; a tick without a toggle gives no frame.
module multichannel_square_tone_shifter
   import mcst_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   mcst_req_if.sink    req_bus,
   mcst_rsp_if.source  rsp_bus
);

   localparam int IDX_W = CHAN_W + 1;

   logic                    s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]         s1_op_ff;
   logic [CHAN_W-1:0]       s1_channel_ff;
   logic [PERIOD_W-1:0]     s1_period_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;

   logic [NUM_CHANNELS-1:0] out_bits_ff, out_bits_in;
   logic [NUM_CHANNELS-1:0] led_bits_ff, led_bits_in;
   logic [NUM_CHANNELS-1:0] sel;
   logic [NUM_CHANNELS-1:0] toggles;
   chan_cmd_type            cmds [NUM_CHANNELS];

   logic can_load, advance, take, emit;

   assign can_load = !out_valid_ff || rsp_bus.ready;
   assign advance  = s1_valid_ff && can_load;
   assign req_bus.ready = !s1_valid_ff || can_load;
   assign take     = req_bus.valid && req_bus.ready;
   assign s1_valid_in = take || (s1_valid_ff && !advance);

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         sel[i] = ({1'b0, s1_channel_ff} == IDX_W'(i));
         cmds[i].tick         = (s1_op_ff == OP_TICK);
         cmds[i].load         = (s1_op_ff == OP_NOTE_ON) && sel[i];
         cmds[i].clear_period = (((s1_op_ff == OP_NOTE_OFF) || (s1_op_ff == OP_RESET_CH))
                                 && sel[i])
                                || (s1_op_ff == OP_RESET_ALL) || (s1_op_ff == OP_HALT_ALL);
         cmds[i].clear_count  = (s1_op_ff == OP_RESET_ALL);
         cmds[i].period       = s1_period_ff;
      end
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      mcst_chan u_chan (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cmd     (cmds[g]),
         .toggle  (toggles[g])
      );
   end

   always_comb begin
      out_bits_in = out_bits_ff;
      led_bits_in = led_bits_ff;
      emit        = 1'b1;
      case (s1_op_ff)
         OP_TICK: begin
            out_bits_in = out_bits_ff ^ toggles;
            emit        = |toggles;
         end
         OP_NOTE_ON: begin
            led_bits_in = led_bits_ff | sel;
         end
         OP_NOTE_OFF: begin
            led_bits_in = led_bits_ff & ~sel;
         end
         OP_RESET_CH: begin
            out_bits_in = out_bits_ff & ~sel;
            led_bits_in = led_bits_ff & ~sel;
         end
         OP_RESET_ALL: begin
            out_bits_in = '0;
            led_bits_in = '0;
         end
         OP_HALT_ALL: begin
            led_bits_in = '0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      frame_in = (FRAME_W'(led_bits_in) << LED_SHIFT) | FRAME_W'(out_bits_in);
      out_valid_in = advance ? emit : (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_bits_ff  <= '0;
         led_bits_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            out_bits_ff <= out_bits_in;
            led_bits_ff <= led_bits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff      <= req_bus.op;
         s1_channel_ff <= req_bus.channel;
         s1_period_ff  <= req_bus.period;
      end
      if (advance && emit) begin
         frame_ff <= frame_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.frame = frame_ff;

   a_no_frame_without_toggle: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff == OP_TICK) && (toggles == '0) |=> !out_valid_ff)
      else $error("frame produced by a tick that toggled nothing");

   a_reset_all_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff == OP_RESET_ALL) |=> (out_bits_ff == '0) && (led_bits_ff == '0))
      else $error("reset-all left output or LED bits set");

   a_halt_keeps_outputs: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff == OP_HALT_ALL) |=> (led_bits_ff == '0) && $stable(out_bits_ff))
      else $error("halt did not clear LEDs or disturbed output bits");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_valid_ff && out_valid_ff && !rsp_bus.ready)
      else $error("command stage refused a beat without a stalled frame");

endmodule

// ----- test/tb_multichannel_square_tone_shifter.sv -----
// Self-checking testbench for the multichannel square tone shifter.
`timescale 1ns / 1ps

module tb_multichannel_square_tone_shifter;
   import mcst_pkg::*;

   localparam int CHANNELS = 8;

   // Op codes the block does not define; it must swallow them silently.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic clock;
   logic reset;

   mcst_req_if req_bus ();
   mcst_rsp_if rsp_bus ();

   multichannel_square_tone_shifter #(
      .NUM_CHANNELS(CHANNELS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the tone generator state.
   logic [PERIOD_W-1:0] shadow_period [CHANNELS];
   logic [PERIOD_W-1:0] shadow_count  [CHANNELS];
   logic [CHANNELS-1:0] shadow_outputs;
   logic [CHANNELS-1:0] shadow_leds;

   logic [FRAME_W-1:0] frames_due [$];
   int                 fail_count;
   bit                 gaps_on;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] want,
                                  input logic [FRAME_W-1:0] got);
      $display("MISMATCH at %0t: %s, expected frame %06h, got %06h", $realtime, what, want,
               got);
      fail_count++;
   endtask

   function automatic logic [FRAME_W-1:0] current_frame();
      return (FRAME_W'(shadow_leds) << LED_SHIFT) | FRAME_W'(shadow_outputs);
   endfunction

   // Applies one accepted command to the shadow state and queues its frame, if any.
   function automatic void advance_tones(input logic [OP_W-1:0] op,
                                         input logic [CHAN_W-1:0] ch,
                                         input logic [PERIOD_W-1:0] per);
      bit emits;
      bit valid_ch;
      int i;
      emits    = 1'b1;
      valid_ch = (int'(ch) < CHANNELS);
      case (op)
         OP_TICK: begin
            emits = 1'b0;
            for (i = 0; i < CHANNELS; i++) begin
               if (shadow_period[i] != '0) begin
                  shadow_count[i] = shadow_count[i] + 1'b1;
                  if (shadow_count[i] >= shadow_period[i]) begin
                     shadow_outputs[i] = ~shadow_outputs[i];
                     shadow_count[i]   = '0;
                     emits             = 1'b1;
                  end
               end
            end
         end
         OP_NOTE_ON: begin
            if (valid_ch) begin
               shadow_period[ch] = per;
               shadow_leds[ch]   = 1'b1;
            end
         end
         OP_NOTE_OFF: begin
            if (valid_ch) begin
               shadow_period[ch] = '0;
               shadow_leds[ch]   = 1'b0;
            end
         end
         OP_RESET_CH: begin
            if (valid_ch) begin
               shadow_period[ch]  = '0;
               shadow_outputs[ch] = 1'b0;
               shadow_leds[ch]    = 1'b0;
            end
         end
         OP_RESET_ALL: begin
            for (i = 0; i < CHANNELS; i++) begin
               shadow_period[i] = '0;
               shadow_count[i]  = '0;
            end
            shadow_outputs = '0;
            shadow_leds    = '0;
         end
         OP_HALT_ALL: begin
            for (i = 0; i < CHANNELS; i++) begin
               shadow_period[i] = '0;
            end
            shadow_leds = '0;
         end
         default: begin
            emits = 1'b0;
         end
      endcase
      if (emits) frames_due.push_back(current_frame());
   endfunction

   // Presents one command beat and returns in the step where it is accepted.
   task automatic send_command(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                               input logic [PERIOD_W-1:0] per);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.channel <= ch;
      req_bus.period  <= per;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_tones(op, ch, per);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      // A trailing tick without a toggle may still be in flight.
      repeat (6) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      gaps_on = 1'b0;
      send_command(OP_TICK, 3'd0, 16'd0);          // nothing playing, no frame
      send_command(OP_SPARE_A, 3'd7, 16'hFFFF);
      send_command(OP_SPARE_B, 3'd0, 16'h0000);
      send_command(OP_NOTE_ON, 3'd0, 16'd1);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_NOTE_ON, 3'd7, 16'd0);       // lit but silent
      send_command(OP_NOTE_ON, 3'd5, 16'hFFFF);
      send_command(OP_NOTE_ON, 3'd1, 16'd5);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_TICK, 3'd0, 16'd0);
      // The counter of channel 1 now sits above the new half-period.
      send_command(OP_NOTE_ON, 3'd1, 16'd2);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_NOTE_OFF, 3'd0, 16'd0);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_RESET_CH, 3'd1, 16'd0);
      send_command(OP_NOTE_ON, 3'd2, 16'd1);
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_HALT_ALL, 3'd0, 16'd0);      // output bits survive a halt
      send_command(OP_TICK, 3'd0, 16'd0);
      send_command(OP_NOTE_ON, 3'd4, 16'h8000);
      send_command(OP_RESET_ALL, 3'd0, 16'd0);
      send_command(OP_RESET_CH, 3'd7, 16'd0);
      send_command(OP_NOTE_OFF, 3'd6, 16'd0);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int beats);
      int                  sent;
      int                  pick;
      logic [OP_W-1:0]     op;
      logic [CHAN_W-1:0]   ch;
      logic [PERIOD_W-1:0] per;
      sent = 0;
      while (sent < beats) begin
         // Alternate stretches with random gaps and stretches at full rate.
         gaps_on = ((sent / 150) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < 55)      op = OP_TICK;
         else if (pick < 75) op = OP_NOTE_ON;
         else if (pick < 83) op = OP_NOTE_OFF;
         else if (pick < 89) op = OP_RESET_CH;
         else if (pick < 92) op = OP_RESET_ALL;
         else if (pick < 94) op = OP_HALT_ALL;
         else if (pick < 97) op = OP_SPARE_A;
         else                op = OP_SPARE_B;
         ch  = CHAN_W'($urandom_range(0, 7));
         // Mostly short periods so that channels actually toggle.
         per = ($urandom_range(0, 4) == 0) ? PERIOD_W'($urandom_range(0, 65535))
                                           : PERIOD_W'($urandom_range(0, 6));
         send_command(op, ch, per);
         sent++;
      end
      wait_drained();
   endtask

   // Result side: random stalls before each frame beat while gaps are on.
   initial begin
      int stall;
      forever begin
         stall = gaps_on ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frames_due.size() == 0) begin
            report_mismatch("frame beat with none expected", '0, rsp_bus.frame);
         end else if (rsp_bus.frame !== frames_due[0]) begin
            report_mismatch("frame field", frames_due[0], rsp_bus.frame);
            void'(frames_due.pop_front());
         end else begin
            void'(frames_due.pop_front());
         end
      end
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int i;
      fail_count      = 0;
      gaps_on         = 1'b1;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.op      <= OP_TICK;
      req_bus.channel <= '0;
      req_bus.period  <= '0;
      for (i = 0; i < CHANNELS; i++) begin
         shadow_period[i] = '0;
         shadow_count[i]  = '0;
      end
      shadow_outputs = '0;
      shadow_leds    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(1450);

      if (frames_due.size() != 0) begin
         report_mismatch("frame never delivered", frames_due[0], '0);
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mcst_pkg.sv
hw/rtl/mcst_if.sv
hw/rtl/mcst_chan.sv
hw/rtl/multichannel_square_tone_shifter.sv
test/tb_multichannel_square_tone_shifter.sv
